// ===== design/kernel_row_cache_directory_top_macros.svh =====
// Assertion macros for the kernel row cache directory checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef KERNEL_ROW_CACHE_DIRECTORY_TOP_MACROS_SVH
`define KERNEL_ROW_CACHE_DIRECTORY_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define KCRD_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("kcrd: invariant violated");

// Check a consequence in the same cycle as its antecedent.
`define KCRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kcrd: same-cycle implication violated");

// Check a consequence in the cycle after its antecedent.
`define KCRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kcrd: next-cycle implication violated");

`endif

// ===== design/kcrd_pkg.sv =====
// Shared types and constants for the kernel row cache directory.
// No dependencies; used by every other file of the block but the macro header and the stream interface.
`timescale 1ns / 1ps

package kcrd_pkg;

  localparam int REG_W  = 7;
  localparam int ROW_W  = 16;
  localparam int SLOT_W = 16;

  localparam logic [REG_W-1:0] CFG_RESET = 7'd64;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
  } in_payload_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
  } out_payload_t;

  typedef struct packed {
    logic [REG_W-1:0] cache_entries;
  } cfg_payload_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_MOD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic hit_take;
    logic fill;
    logic mod_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic full_mode;
    logic empty_dir;
    logic match;
    logic scan_miss;
    logic mod_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== design/kcrd_stream_if.sv =====
// Valid/ready channel with a typed payload.
// Payload types come from kcrd_pkg at the point of instantiation.
`timescale 1ns / 1ps

interface kcrd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/kcrd_datapath.sv =====
// Datapath: configuration register, tag memory, fill count and pointer,
// scan pipeline, remainder unit and output register. Uses kcrd_pkg.
`timescale 1ns / 1ps

module kcrd_datapath #(
  parameter int ENTRIES  = 64,
  parameter int MAX_ROWS = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [kcrd_pkg::REG_W-1:0]   cfg_data,
  input  logic [kcrd_pkg::ROW_W-1:0]   row_in,
  input  kcrd_pkg::dp_cmd_t            cmd,
  output kcrd_pkg::dp_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kcrd_pkg::SLOT_W-1:0]  out_slot,
  output logic                         out_hit
);

  localparam int REG_W  = kcrd_pkg::REG_W;
  localparam int ROW_W  = kcrd_pkg::ROW_W;
  localparam int SLOT_W = kcrd_pkg::SLOT_W;
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > REG_W) ? CNT_W : REG_W;
  localparam int MR_W   = $clog2(MAX_ROWS + 1);
  localparam int MOD_L  = $clog2(MAX_ROWS);
  localparam int MOD_SH = ROW_W + MOD_L;
  localparam int RC_W   = ROW_W + 2;
  localparam int PR_W   = ROW_W + RC_W;
  localparam int QD_W   = ROW_W + MR_W;
  localparam longint RECIP =
    ((longint'(1) << MOD_SH) + longint'(MAX_ROWS) - longint'(1)) / longint'(MAX_ROWS);
  localparam logic [RC_W-1:0] RECIP_C = RC_W'(RECIP);

  logic [REG_W-1:0]  cache_entries_r;
  logic [CNT_W-1:0]  fill_cnt_r;
  logic [IDX_W-1:0]  fill_ptr_r;
  logic [ROW_W-1:0]  row_r;
  logic [IDX_W-1:0]  addr_r;
  logic              issuing_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [ROW_W-1:0]  rd_tag_r;
  logic              mod_ph_r;
  logic [PR_W-1:0]   prod_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              res_hit_r;
  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_hit_r;

  logic [ROW_W-1:0]  tag_mem [ENTRIES];

  logic [CMP_W-1:0]  ents_w;
  logic [CMP_W-1:0]  n_w;
  logic [CMP_W-1:0]  cnt_w;
  logic [CMP_W-1:0]  lim_w;
  logic [CMP_W-1:0]  lim_m1_w;
  logic [CMP_W-1:0]  ptr_w;
  logic [CMP_W-1:0]  p_w;
  logic [CMP_W-1:0]  p1_w;
  logic [IDX_W-1:0]  fill_ptr_nxt;
  logic [ROW_W-1:0]  quo_w;
  logic [ROW_W-1:0]  qd_w;
  logic [ROW_W-1:0]  rem_w;
  logic              tag_eq;

  always_comb begin
    ents_w   = CMP_W'(cache_entries_r);
    n_w      = (ents_w > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : ents_w;
    cnt_w    = CMP_W'(fill_cnt_r);
    lim_w    = (n_w < cnt_w) ? n_w : cnt_w;
    lim_m1_w = lim_w - CMP_W'(1);
    ptr_w    = CMP_W'(fill_ptr_r);
    p_w      = (ptr_w < n_w) ? ptr_w : '0;
    p1_w     = p_w + CMP_W'(1);
    fill_ptr_nxt = (p1_w == n_w) ? '0 : IDX_W'(p1_w);
    quo_w    = ROW_W'(prod_r >> MOD_SH);
    qd_w     = ROW_W'(QD_W'(quo_w) * QD_W'(MAX_ROWS));
    rem_w    = row_r - qd_w;
    tag_eq   = (rd_tag_r == row_r);
  end

  always_comb begin
    sts.full_mode = (n_w == '0);
    sts.empty_dir = (lim_w == '0);
    sts.match     = rd_vld_r && tag_eq;
    sts.scan_miss = rd_vld_r && !tag_eq && (rd_idx_r == '0);
    sts.mod_last  = mod_ph_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_entries_r <= kcrd_pkg::CFG_RESET;
      fill_cnt_r      <= '0;
      fill_ptr_r      <= '0;
      issuing_r       <= 1'b0;
      rd_vld_r        <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        cache_entries_r <= cfg_data;
      end
      if (cmd.accept) begin
        issuing_r <= 1'b1;
        rd_vld_r  <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_vld_r <= issuing_r;
        if (issuing_r && (addr_r == '0)) begin
          issuing_r <= 1'b0;
        end
      end
      if (cmd.fill) begin
        fill_ptr_r <= fill_ptr_nxt;
        if (p1_w > cnt_w) begin
          fill_cnt_r <= CNT_W'(p1_w);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r <= IDX_W'(lim_m1_w);
    end else if (cmd.scan_step && issuing_r && (addr_r != '0)) begin
      addr_r <= addr_r - IDX_W'(1);
    end
    if (cmd.scan_step && issuing_r) begin
      rd_tag_r <= tag_mem[addr_r];
      rd_idx_r <= addr_r;
    end
    if (cmd.fill) begin
      tag_mem[IDX_W'(p_w)] <= row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_r    <= row_in;
      mod_ph_r <= 1'b0;
    end else if (cmd.mod_step) begin
      mod_ph_r <= 1'b1;
      if (!mod_ph_r) begin
        prod_r <= PR_W'(row_r) * PR_W'(RECIP_C);
      end
    end
    if (cmd.hit_take) begin
      res_slot_r <= SLOT_W'(rd_idx_r);
      res_hit_r  <= 1'b1;
    end else if (cmd.fill) begin
      res_slot_r <= SLOT_W'(p_w);
      res_hit_r  <= 1'b0;
    end else if (cmd.mod_step && mod_ph_r) begin
      res_slot_r <= SLOT_W'(rem_w);
      res_hit_r  <= 1'b1;
    end
    if (cmd.out_load) begin
      out_slot_r <= res_slot_r;
      out_hit_r  <= res_hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_slot  = out_slot_r;
  assign out_hit   = out_hit_r;

endmodule

// ===== design/kcrd_ctrl.sv =====
// Controller state machine: sequences accept, tag scan, refill,
// full-mode remainder and result hand-off. Uses kcrd_pkg.
`timescale 1ns / 1ps

module kcrd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kcrd_pkg::dp_sts_t sts,
  output kcrd_pkg::dp_cmd_t cmd
);

  kcrd_pkg::state_t state_r;
  kcrd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kcrd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      kcrd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.full_mode) begin
            state_nxt = kcrd_pkg::ST_MOD;
          end else if (sts.empty_dir) begin
            state_nxt = kcrd_pkg::ST_FILL;
          end else begin
            state_nxt = kcrd_pkg::ST_SCAN;
          end
        end
      end
      kcrd_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.match) begin
          cmd.hit_take = 1'b1;
          state_nxt    = kcrd_pkg::ST_DONE;
        end else if (sts.scan_miss) begin
          state_nxt = kcrd_pkg::ST_FILL;
        end
      end
      kcrd_pkg::ST_FILL: begin
        cmd.fill  = 1'b1;
        state_nxt = kcrd_pkg::ST_DONE;
      end
      kcrd_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = kcrd_pkg::ST_DONE;
        end
      end
      kcrd_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = kcrd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kcrd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/kernel_row_cache_directory_top.sv =====
// Kernel row cache directory: fully associative tag directory with round-robin
// refill for a cache of computed kernel rows. One request in, one result out; the
// block works on one request at a time. The tag memory has a single read port and
// is scanned one slot per cycle from the highest valid slot in use downwards,
// stopping at the first match. With cache_entries at zero the slot is row_index
// mod MAX_ROWS, worked out by a reciprocal multiplication and a subtraction.
// A finished result sits in an output register, so the next request is taken
// while it waits. Valid slots are tracked by a fill count, so reset needs no
// clearing pass.
`timescale 1ns / 1ps

module kernel_row_cache_directory_top #(
  parameter int ENTRIES  = 64,
  parameter int MAX_ROWS = 65536
) (
  input logic           clk,
  input logic           rst_n,
  kcrd_stream_if.sink   in_ch,
  kcrd_stream_if.source out_ch,
  kcrd_stream_if.sink   cfg_ch
);

  kcrd_pkg::dp_cmd_t cmd;
  kcrd_pkg::dp_sts_t sts;
  logic              in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  kcrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kcrd_datapath #(
    .ENTRIES  (ENTRIES),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data.cache_entries),
    .row_in    (in_ch.data.row_index),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_slot  (out_ch.data.slot),
    .out_hit   (out_ch.data.hit)
  );

endmodule

// ===== design/kcrd_checker.sv =====
// Port-level checker for the kernel row cache directory, bound to the top level.
// Depends on kcrd_pkg and kernel_row_cache_directory_top_macros.svh.
`timescale 1ns / 1ps
`include "kernel_row_cache_directory_top_macros.svh"

module kcrd_checker #(
  parameter int ENTRIES = 64
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [kcrd_pkg::SLOT_W-1:0] out_slot,
  input logic                        out_hit
);

  localparam int SLOT_W = kcrd_pkg::SLOT_W;
  localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(ENTRIES);

  logic [1:0] pend_r;
  logic [1:0] pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if (in_valid && in_ready) begin
      pend_nxt = pend_nxt + 2'd1;
    end
    if (out_valid && out_ready) begin
      pend_nxt = pend_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `KCRD_ASSERT_ALWAYS(a_pend_bound, pend_r != 2'd3)
  `KCRD_ASSERT_IMP(a_out_has_item, out_valid, pend_r != 2'd0)
  `KCRD_ASSERT_IMP(a_miss_slot_range, out_valid && !out_hit, out_slot < SLOT_LIMIT)
  `KCRD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_slot) && $stable(out_hit))

endmodule

bind kernel_row_cache_directory_top kcrd_checker #(
  .ENTRIES (ENTRIES)
) u_kcrd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_slot  (out_ch.data.slot),
  .out_hit   (out_ch.data.hit)
);
